// ===== design/scrm_pkg.sv =====
// Package with the request, result and circle table types of the circle ray marcher.
`timescale 1ns / 1ps
`default_nettype none
package scrm_pkg;

    localparam int COORD_W = 24;
    localparam int RAD_W   = 23;
    localparam int EMI_W   = 16;
    localparam int DIR_W   = 16;
    localparam int STEP_W  = 8;
    localparam int CC_W    = 5;
    localparam int CFG_W   = 23;
    localparam int CIDX_W  = 4;
    localparam int POS_W   = 27;
    localparam int PROD_W  = 40;
    localparam int ABS_W   = 28;
    localparam int SQ_W    = 57;
    localparam int ROOT_W  = 29;
    localparam int DIST_W  = 31;
    localparam logic [RAD_W-1:0] T_SAT = {RAD_W{1'b1}};

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_TRACE = 1'b1;

    localparam logic [1:0] CFG_CIRCLE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_MAX_STEPS     = 2'd1;
    localparam logic [1:0] CFG_MAX_DISTANCE  = 2'd2;
    localparam logic [1:0] CFG_HIT_THRESHOLD = 2'd3;

    typedef struct packed {
        logic                       op;
        logic [CIDX_W-1:0]          circle_index;
        logic signed [COORD_W-1:0]  circle_x;
        logic signed [COORD_W-1:0]  circle_y;
        logic [RAD_W-1:0]           circle_radius;
        logic [EMI_W-1:0]           circle_emission;
        logic signed [COORD_W-1:0]  origin_x;
        logic signed [COORD_W-1:0]  origin_y;
        logic signed [DIR_W-1:0]    dir_x;
        logic signed [DIR_W-1:0]    dir_y;
    } t_in_req;

    typedef struct packed {
        logic [EMI_W-1:0] emission;
        logic             hit;
    } t_out_res;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RAD_W-1:0]          rad;
        logic [EMI_W-1:0]          emi;
    } t_circle;

endpackage
`default_nettype wire

// ===== design/sdf_circle_ray_march_core.sv =====
// Top level of the 2D circle signed-distance ray marcher.
//
// Requests enter on i_in_valid / o_in_ready with payload i_in. A load request
// writes one circle slot and gives no result. A trace request marches a ray
// and gives one result on o_out_valid / i_out_ready.
// Each march step checks its limits and scales the direction by the ray
// parameter with two multipliers, then visits every circle in turn: position
// and table read, absolute deltas, squared sum, a bit-serial square root and
// a compare. The step ends with the hit test.
// The block takes one request at a time.
// The result sits in an output register, so a new request is accepted while
// the previous result waits for the receiver. A finished trace holds in its
// last state while that register is still occupied.
// Reset clears the control state and the configuration registers to their
// defaults; the circle table is undefined until loaded.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_wdata.
`timescale 1ns / 1ps
`default_nettype none
module sdf_circle_ray_march_core #(
    parameter int MAX_CIRCLES = 16
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire scrm_pkg::t_in_req     i_in,
    output logic                       o_out_valid,
    input  wire                        i_out_ready,
    output scrm_pkg::t_out_res         o_out,
    input  wire                        i_cfg_we,
    input  wire [1:0]                  i_cfg_index,
    input  wire [scrm_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import scrm_pkg::*;

    localparam int AW  = (MAX_CIRCLES > 1) ? $clog2(MAX_CIRCLES) : 1;
    localparam int CW0 = $clog2(MAX_CIRCLES + 1);
    localparam int CW  = (CW0 > CC_W) ? CW0 : CC_W;
    localparam int TW  = $bits(t_circle);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_POS   = 9'b000001000,
        S_RD    = 9'b000010000,
        S_SQ    = 9'b000100000,
        S_SQRT  = 9'b001000000,
        S_CMP   = 9'b010000000,
        S_EVAL  = 9'b100000000
    } t_state;

    t_state r_state;
    logic   r_done;

    logic [CC_W-1:0]   r_cc;
    logic [STEP_W-1:0] r_max_steps;
    logic [RAD_W-1:0]  r_max_dist;
    logic [EMI_W-1:0]  r_thr;

    logic signed [COORD_W-1:0] r_ox, r_oy;
    logic signed [DIR_W-1:0]   r_dx, r_dy;
    logic [RAD_W-1:0]          r_t;
    logic [STEP_W-1:0]         r_step;
    logic [CW-1:0]             r_k;
    logic [CW-1:0]             r_count;
    logic signed [PROD_W-1:0]  r_mx, r_my;
    logic signed [POS_W-1:0]   r_px, r_py;
    logic [ABS_W-1:0]          r_ax, r_ay;
    logic [SQ_W-1:0]           r_rem, r_res, r_bit;
    logic signed [DIST_W-1:0]  r_best;
    logic [EMI_W-1:0]          r_best_emi;
    t_out_res                  r_res_q;

    logic                      in_acc;
    logic                      ram_we;
    logic [CW-1:0]             idx_ext;
    t_circle                   wdata, rdata;
    logic [TW-1:0]             rdata_raw;
    logic                      out_free;
    logic signed [PROD_W-1:0]  rx, ry;
    logic signed [ABS_W-1:0]   ddx, ddy;
    logic [SQ_W-1:0]           sum_try;
    logic signed [DIST_W-1:0]  circ_dist;
    logic [DIST_W:0]           t_sum;
    logic [CW-1:0]             cnt_eff;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ext    = CW'(i_in.circle_index);
    assign ram_we     = in_acc && (i_in.op == OP_LOAD) && (idx_ext < CW'(MAX_CIRCLES));
    assign wdata      = '{cx: i_in.circle_x, cy: i_in.circle_y,
                          rad: i_in.circle_radius, emi: i_in.circle_emission};
    assign rdata      = t_circle'(rdata_raw);
    assign out_free   = !o_out_valid || i_out_ready;

    scrm_ram #(.WIDTH(TW), .DEPTH(MAX_CIRCLES)) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (TW'(wdata)),
        .i_re    (r_state == S_POS),
        .i_raddr (r_k[AW-1:0]),
        .o_rdata (rdata_raw)
    );

    always_comb begin
        if (r_cc == '0) begin
            cnt_eff = CW'(1);
        end else if (CW'(r_cc) > CW'(MAX_CIRCLES)) begin
            cnt_eff = CW'(MAX_CIRCLES);
        end else begin
            cnt_eff = CW'(r_cc);
        end
        rx        = (r_mx + PROD_W'(8192)) >>> 14;
        ry        = (r_my + PROD_W'(8192)) >>> 14;
        ddx       = ABS_W'(rdata.cx) - ABS_W'(r_px);
        ddy       = ABS_W'(rdata.cy) - ABS_W'(r_py);
        sum_try   = r_res + r_bit;
        circ_dist = $signed({2'b00, r_res[ROOT_W-1:0]}) - $signed(DIST_W'(rdata.rad));
        t_sum     = (DIST_W+1)'(r_t) + (DIST_W+1)'(r_best);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc        <= CC_W'(1);
            r_max_steps <= STEP_W'(10);
            r_max_dist  <= RAD_W'(128000);
            r_thr       <= EMI_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CIRCLE_COUNT:  r_cc        <= i_cfg_wdata[CC_W-1:0];
                CFG_MAX_STEPS:     r_max_steps <= i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_DISTANCE:  r_max_dist  <= i_cfg_wdata[RAD_W-1:0];
                CFG_HIT_THRESHOLD: r_thr       <= i_cfg_wdata[EMI_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_out_ready && !r_done) begin
                o_out_valid <= 1'b0;
            end
            if (r_done) begin
                if (out_free) begin
                    o_out_valid <= 1'b1;
                    o_out       <= r_res_q;
                    r_done      <= 1'b0;
                    r_state     <= S_IDLE;
                end
            end else begin
                unique case (r_state)
                    S_IDLE: begin
                        if (in_acc && i_in.op == OP_TRACE) begin
                            r_ox    <= i_in.origin_x;
                            r_oy    <= i_in.origin_y;
                            r_dx    <= i_in.dir_x;
                            r_dy    <= i_in.dir_y;
                            r_t     <= '0;
                            r_step  <= '0;
                            r_count <= cnt_eff;
                            r_state <= S_CHECK;
                        end
                    end
                    S_CHECK: begin
                        if (r_step < r_max_steps && r_t < r_max_dist) begin
                            r_state <= S_MUL;
                        end else begin
                            r_res_q <= '{emission: '0, hit: 1'b0};
                            r_done  <= 1'b1;
                        end
                    end
                    S_MUL: begin
                        r_mx    <= PROD_W'(r_dx * $signed({1'b0, r_t}));
                        r_my    <= PROD_W'(r_dy * $signed({1'b0, r_t}));
                        r_k     <= '0;
                        r_state <= S_POS;
                    end
                    S_POS: begin
                        r_px    <= POS_W'(r_ox) + POS_W'(rx);
                        r_py    <= POS_W'(r_oy) + POS_W'(ry);
                        r_state <= S_RD;
                    end
                    S_RD: begin
                        r_ax    <= ddx[ABS_W-1] ? ABS_W'(-ddx) : ABS_W'(ddx);
                        r_ay    <= ddy[ABS_W-1] ? ABS_W'(-ddy) : ABS_W'(ddy);
                        r_state <= S_SQ;
                    end
                    S_SQ: begin
                        r_rem   <= SQ_W'(r_ax * r_ax) + SQ_W'(r_ay * r_ay);
                        r_res   <= '0;
                        r_bit   <= SQ_W'(1) << (SQ_W - 1);
                        r_state <= S_SQRT;
                    end
                    S_SQRT: begin
                        if (r_rem >= sum_try) begin
                            r_rem <= r_rem - sum_try;
                            r_res <= (r_res >> 1) + r_bit;
                        end else begin
                            r_res <= r_res >> 1;
                        end
                        r_bit <= r_bit >> 2;
                        if (r_bit[0]) begin
                            r_state <= S_CMP;
                        end
                    end
                    S_CMP: begin
                        if (r_k == '0 || !(r_best < circ_dist)) begin
                            r_best     <= circ_dist;
                            r_best_emi <= rdata.emi;
                        end
                        if (r_k + CW'(1) < r_count) begin
                            r_k     <= r_k + CW'(1);
                            r_state <= S_POS;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                    S_EVAL: begin
                        if (r_best < $signed(DIST_W'(r_thr))) begin
                            r_res_q <= '{emission: r_best_emi, hit: 1'b1};
                            r_done  <= 1'b1;
                        end else begin
                            r_t     <= (t_sum > (DIST_W+1)'(T_SAT)) ? T_SAT
                                                                   : t_sum[RAD_W-1:0];
                            r_step  <= r_step + STEP_W'(1);
                            r_state <= S_CHECK;
                        end
                    end
                    default: r_state <= S_IDLE;
                endcase
            end
        end
    end

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_k < r_count))
        else $error("circle index beyond count");
    a_trace_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_TRACE) |=> (r_state == S_CHECK))
        else $error("trace did not start");
    a_load_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.op == OP_LOAD) |=> (r_state == S_IDLE))
        else $error("load left idle");
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_step < r_max_steps))
        else $error("step beyond limit");
endmodule
`default_nettype wire

// ===== design/scrm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module scrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                                         i_clk,
    input  wire                                         i_we,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                             i_wdata,
    input  wire                                         i_re,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire
